/* rtl/trht_pkg.sv */
// trht_pkg: shared types and constants for the touch region hit test block
// no dependencies; imported by trht_map, touch_region_hit_test_top, trht_checker and tb

package trht_pkg;

  localparam int unsigned MAX_REGIONS = 16;
  localparam int unsigned IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_REGIONS + 1);

  localparam int unsigned RAW_W = 16;
  localparam int unsigned SX_W = 8;
  localparam int unsigned SY_W = 9;
  localparam int unsigned Q_W = 10;

  localparam int unsigned RAW_X_MIN = 2000;
  localparam int unsigned RAW_Y_MIN = 3000;
  localparam int unsigned SCREEN_X_MAX = 239;
  localparam int unsigned SCREEN_Y_MAX = 319;

  // x: a*240/28000 = a*3/350, y: a*320/27000 = a*8/675, both via ceil reciprocals
  localparam int unsigned RECIP_SHIFT = 26;
  localparam int unsigned PROD_W = 36;
  localparam longint unsigned X_RECIP = 3 * ((2**RECIP_SHIFT + 349) / 350);
  localparam longint unsigned Y_RECIP = (2**(RECIP_SHIFT + 3) + 674) / 675;

  localparam int unsigned HOLD_W = 20;
  localparam logic [HOLD_W-1:0] HOLD_OFF_RESET = 20'd500000;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_TOUCH = 1'b1;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] y_high;
    logic [15:0] y_low;
    logic [15:0] x_high;
    logic [15:0] x_low;
  } region_t;

endpackage

/* rtl/touch_region_hit_test_top.sv */
// touch_region_hit_test_top: region table, hold-off check and scan sequencer
// depends on trht_pkg and trht_map

// An add beat leaves busy low, so adds may come every cycle while no touch
// holds busy; its result strobes in the next cycle. A touch beat inside the
// hold-off window also answers in the next cycle. Any other touch holds busy
// high through the mapping states S_MUL and S_MAP, the second of which fetches
// the first entry, and then through the scan, which examines one entry per
// cycle from the region memory up to and including the first hit (every entry
// on a miss, none with an empty table). busy falls at the edge that raises the
// result strobe. The result is on the out_ ports for exactly one cycle with
// out_strobe and cannot be held off, so it must be captured when it appears.
module touch_region_hit_test_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_operation,
  input  logic [15:0]               in_raw_x,
  input  logic [15:0]               in_raw_y,
  input  logic [31:0]               in_now_sec,
  input  logic [19:0]               in_now_usec,
  input  logic [15:0]               in_region_x_low,
  input  logic [15:0]               in_region_x_high,
  input  logic [15:0]               in_region_y_low,
  input  logic [15:0]               in_region_y_high,
  input  logic [15:0]               in_region_id,
  input  logic                      cfg_wr_en,
  input  logic [trht_pkg::HOLD_W-1:0] cfg_wr_data,
  output logic                      out_strobe,
  output logic                      out_hit_valid,
  output logic [15:0]               out_hit_id,
  output logic                      out_add_dropped
);
  import trht_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_MAP  = 2'd2;
  localparam logic [1:0] S_SCAN = 2'd3;

  region_t         mem [MAX_REGIONS];
  region_t         rd_q;
  logic [IDX_W-1:0] rd_addr;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [31:0]      last_sec_r, last_sec_nxt;
  logic [HOLD_W-1:0] last_usec_r, last_usec_nxt;
  logic [HOLD_W-1:0] hold_off_r;
  logic [15:0]      raw_x_r, raw_y_r;
  logic [31:0]      now_sec_r;
  logic [HOLD_W-1:0] now_usec_r;
  logic             strobe_r, strobe_nxt;
  logic             hit_valid_r, hit_valid_nxt;
  logic [15:0]      hit_id_r, hit_id_nxt;
  logic             dropped_r, dropped_nxt;

  logic             accept;
  logic             full;
  logic             mem_we;
  logic             held_off;
  logic signed [HOLD_W+1:0] dt;
  logic [SX_W-1:0]  sx;
  logic [SY_W-1:0]  sy;
  logic             entry_hit;
  logic             last_entry;

  trht_map u_map (
    .clk   (clk),
    .raw_x (raw_x_r),
    .raw_y (raw_y_r),
    .sx    (sx),
    .sy    (sy)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign full   = (count_r >= CNT_W'(MAX_REGIONS));
  assign mem_we = accept && (in_operation == OP_ADD) && !full;

  assign dt = $signed({2'b00, in_now_usec}) - $signed({2'b00, last_usec_r});
  assign held_off = (in_now_sec == last_sec_r) && (dt < $signed({2'b00, hold_off_r}));

  assign entry_hit = ({8'd0, sx} > rd_q.x_low) && ({8'd0, sx} < rd_q.x_high) &&
                     ({7'd0, sy} > rd_q.y_low) && ({7'd0, sy} < rd_q.y_high);
  assign last_entry = (CNT_W'(idx_r) + 1'b1) == count_r;

  assign rd_addr = (state_r == S_SCAN) ? IDX_W'(idx_r + 1'b1) : '0;

  // region memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[IDX_W-1:0]] <= '{id: in_region_id, y_high: in_region_y_high,
                                   y_low: in_region_y_low, x_high: in_region_x_high,
                                   x_low: in_region_x_low};
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    last_sec_nxt  = last_sec_r;
    last_usec_nxt = last_usec_r;
    strobe_nxt    = 1'b0;
    hit_valid_nxt = 1'b0;
    hit_id_nxt    = '0;
    dropped_nxt   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_operation == OP_ADD) begin
            strobe_nxt = 1'b1;
            if (full) begin
              dropped_nxt = 1'b1;
            end else begin
              count_nxt = count_r + 1'b1;
            end
          end else if (held_off) begin
            strobe_nxt = 1'b1;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        state_nxt = S_MAP;
      end
      S_MAP: begin
        idx_nxt = '0;
        if (count_r == '0) begin
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (entry_hit) begin
          strobe_nxt    = 1'b1;
          hit_valid_nxt = 1'b1;
          hit_id_nxt    = rd_q.id;
          last_sec_nxt  = now_sec_r;
          last_usec_nxt = now_usec_r;
          state_nxt     = S_IDLE;
        end else if (last_entry) begin
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      last_sec_r  <= '0;
      last_usec_r <= '0;
      hold_off_r  <= HOLD_OFF_RESET;
      strobe_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      last_sec_r  <= last_sec_nxt;
      last_usec_r <= last_usec_nxt;
      strobe_r    <= strobe_nxt;
      if (cfg_wr_en) begin
        hold_off_r <= cfg_wr_data;
      end
    end
  end

  // beat payload and result payload
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    hit_valid_r <= hit_valid_nxt;
    hit_id_r    <= hit_id_nxt;
    dropped_r   <= dropped_nxt;
    if (accept) begin
      raw_x_r    <= in_raw_x;
      raw_y_r    <= in_raw_y;
      now_sec_r  <= in_now_sec;
      now_usec_r <= in_now_usec;
    end
  end

  assign out_strobe      = strobe_r;
  assign out_hit_valid   = hit_valid_r;
  assign out_hit_id      = hit_id_r;
  assign out_add_dropped = dropped_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_REGIONS))
    else $error("region count beyond table size");

  a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> !(hit_valid_r && dropped_r))
    else $error("hit and drop in one result");

  a_hit_records_time: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && hit_valid_r) |-> (last_sec_r == now_sec_r && last_usec_r == now_usec_r))
    else $error("hit did not record its time");

  a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (CNT_W'(idx_r) < count_r))
    else $error("scan past last region");

  a_busy_no_strobe_add: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_operation == OP_TOUCH && !held_off) |=> !strobe_r)
    else $error("touch answered before mapping");

endmodule

/* rtl/trht_map.sv */
// trht_map: two-stage raw to screen coordinate mapping with clamping
// depends on trht_pkg

module trht_map (
  input  logic                    clk,
  input  logic [trht_pkg::RAW_W-1:0] raw_x,
  input  logic [trht_pkg::RAW_W-1:0] raw_y,
  output logic [trht_pkg::SX_W-1:0]  sx,
  output logic [trht_pkg::SY_W-1:0]  sy
);
  import trht_pkg::*;

  logic [RAW_W:0]    ax;
  logic [RAW_W:0]    ay;
  logic              neg_x_r;
  logic              neg_y_r;
  logic [PROD_W-1:0] prod_x_r;
  logic [PROD_W-1:0] prod_y_r;
  logic [Q_W-1:0]    qx;
  logic [Q_W-1:0]    qy;
  logic [SX_W-1:0]   sx_r;
  logic [SY_W-1:0]   sy_r;

  assign ax = {1'b0, raw_x} - (RAW_W+1)'(RAW_X_MIN);
  assign ay = {1'b0, raw_y} - (RAW_W+1)'(RAW_Y_MIN);

  // stage one: offset and reciprocal multiply
  always_ff @(posedge clk) begin
    neg_x_r  <= ax[RAW_W];
    neg_y_r  <= ay[RAW_W];
    prod_x_r <= PROD_W'(ax[RAW_W-1:0]) * PROD_W'(X_RECIP);
    prod_y_r <= PROD_W'(ay[RAW_W-1:0]) * PROD_W'(Y_RECIP);
  end

  assign qx = prod_x_r[PROD_W-1:RECIP_SHIFT];
  assign qy = prod_y_r[PROD_W-1:RECIP_SHIFT];

  // stage two: mirror x and clamp to the screen
  always_ff @(posedge clk) begin
    if (neg_x_r) begin
      sx_r <= SX_W'(SCREEN_X_MAX);
    end else if (qx >= Q_W'(SCREEN_X_MAX)) begin
      sx_r <= '0;
    end else begin
      sx_r <= SX_W'(Q_W'(SCREEN_X_MAX) - qx);
    end
    if (neg_y_r) begin
      sy_r <= '0;
    end else if (qy > Q_W'(SCREEN_Y_MAX)) begin
      sy_r <= SY_W'(SCREEN_Y_MAX);
    end else begin
      sy_r <= qy[SY_W-1:0];
    end
  end

  assign sx = sx_r;
  assign sy = sy_r;

endmodule

/* tb/trht_checker.sv */
// trht_checker: watches the beat and result ports of touch_region_hit_test_top,
// predicts each result from its own copy of the region table and hold-off state
// depends on trht_pkg; instantiated by tb beside the block

module trht_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        in_operation,
  input  logic [15:0]                 in_raw_x,
  input  logic [15:0]                 in_raw_y,
  input  logic [31:0]                 in_now_sec,
  input  logic [19:0]                 in_now_usec,
  input  logic [15:0]                 in_region_x_low,
  input  logic [15:0]                 in_region_x_high,
  input  logic [15:0]                 in_region_y_low,
  input  logic [15:0]                 in_region_y_high,
  input  logic [15:0]                 in_region_id,
  input  logic                        cfg_wr_en,
  input  logic [trht_pkg::HOLD_W-1:0] cfg_wr_data,
  input  logic                        out_strobe,
  input  logic                        out_hit_valid,
  input  logic [15:0]                 out_hit_id,
  input  logic                        out_add_dropped,
  output int                          mismatches,
  output int                          results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  import trht_pkg::*;

  localparam int X_ORIGIN = 2000;
  localparam int X_SPAN = 28000;
  localparam int Y_ORIGIN = 3000;
  localparam int Y_SPAN = 27000;
  localparam int SCREEN_WIDTH = 240;
  localparam int SCREEN_HEIGHT = 320;

  typedef struct packed {
    logic        hit_valid;
    logic [15:0] hit_id;
    logic        add_dropped;
  } hit_result_t;

  hit_result_t       hit_results_due[$];
  region_t           table_copy[MAX_REGIONS];
  int                table_fill;
  logic [31:0]       last_hit_sec;
  logic [HOLD_W-1:0] last_hit_usec;
  logic [HOLD_W-1:0] hold_off;

  function automatic int clamp_to(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic hit_result_t predict_hit(logic op, logic [15:0] rx, logic [15:0] ry,
                                              logic [31:0] sec, logic [19:0] usec,
                                              region_t reg_in);
    hit_result_t res;
    int sx;
    int sy;
    res = '0;
    if (op == OP_ADD) begin
      if (table_fill >= int'(MAX_REGIONS)) begin
        res.add_dropped = 1'b1;
      end else begin
        table_copy[table_fill] = reg_in;
        table_fill++;
      end
      return res;
    end
    if (sec == last_hit_sec && (int'(usec) - int'(last_hit_usec)) < int'(hold_off)) return res;
    sx = clamp_to((SCREEN_WIDTH - 1) - (int'(rx) - X_ORIGIN) * SCREEN_WIDTH / X_SPAN,
                  SCREEN_WIDTH - 1);
    sy = clamp_to((int'(ry) - Y_ORIGIN) * SCREEN_HEIGHT / Y_SPAN, SCREEN_HEIGHT - 1);
    for (int i = 0; i < table_fill; i++) begin
      if (sx > int'(table_copy[i].x_low) && sx < int'(table_copy[i].x_high) &&
          sy > int'(table_copy[i].y_low) && sy < int'(table_copy[i].y_high)) begin
        last_hit_sec = sec;
        last_hit_usec = usec;
        res.hit_valid = 1'b1;
        res.hit_id = table_copy[i].id;
        return res;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    hit_result_t want;
    if (!rst_n) begin
      hit_results_due.delete();
      table_fill = 0;
      last_hit_sec = '0;
      last_hit_usec = '0;
      hold_off = HOLD_OFF_RESET;
    end else begin
      if (out_strobe) begin
        if (hit_results_due.size() == 0) begin
          $error("result beat with nothing expected");
          mismatches++;
        end else begin
          want = hit_results_due.pop_front();
          if (out_hit_valid !== want.hit_valid) begin
            $error("hit_valid: expected %0d, got %0d", want.hit_valid, out_hit_valid);
            mismatches++;
          end
          if (out_hit_id !== want.hit_id) begin
            $error("hit_id: expected %h, got %h", want.hit_id, out_hit_id);
            mismatches++;
          end
          if (out_add_dropped !== want.add_dropped) begin
            $error("add_dropped: expected %0d, got %0d", want.add_dropped, out_add_dropped);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        hit_results_due.push_back(predict_hit(in_operation, in_raw_x, in_raw_y, in_now_sec,
                                              in_now_usec,
                                              '{id: in_region_id, y_high: in_region_y_high,
                                                y_low: in_region_y_low,
                                                x_high: in_region_x_high,
                                                x_low: in_region_x_low}));
      end
      if (cfg_wr_en) hold_off = cfg_wr_data;
    end
    results_due = hit_results_due.size();
  end

endmodule

/* tb/tb.sv */
// tb: stimulus and verdict for touch_region_hit_test_top: region adds, touches
// over time and hold-off settings; depends on trht_pkg and trht_checker

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trht_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_operation = OP_ADD;
  logic [15:0]       in_raw_x = '0;
  logic [15:0]       in_raw_y = '0;
  logic [31:0]       in_now_sec = '0;
  logic [19:0]       in_now_usec = '0;
  logic [15:0]       in_region_x_low = '0;
  logic [15:0]       in_region_x_high = '0;
  logic [15:0]       in_region_y_low = '0;
  logic [15:0]       in_region_y_high = '0;
  logic [15:0]       in_region_id = '0;
  logic              cfg_wr_en = 1'b0;
  logic [HOLD_W-1:0] cfg_wr_data = '0;
  logic              out_strobe;
  logic              out_hit_valid;
  logic [15:0]       out_hit_id;
  logic              out_add_dropped;

  int          mismatches;
  int          results_due;
  int          cycles = 0;
  int          adds_sent = 0;
  logic [31:0] clock_sec = '0;
  logic [19:0] clock_usec = '0;

  always #5 clk = ~clk;

  touch_region_hit_test_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_raw_x        (in_raw_x),
    .in_raw_y        (in_raw_y),
    .in_now_sec      (in_now_sec),
    .in_now_usec     (in_now_usec),
    .in_region_x_low (in_region_x_low),
    .in_region_x_high(in_region_x_high),
    .in_region_y_low (in_region_y_low),
    .in_region_y_high(in_region_y_high),
    .in_region_id    (in_region_id),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_strobe      (out_strobe),
    .out_hit_valid   (out_hit_valid),
    .out_hit_id      (out_hit_id),
    .out_add_dropped (out_add_dropped)
  );

  trht_checker hit_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_raw_x        (in_raw_x),
    .in_raw_y        (in_raw_y),
    .in_now_sec      (in_now_sec),
    .in_now_usec     (in_now_usec),
    .in_region_x_low (in_region_x_low),
    .in_region_x_high(in_region_x_high),
    .in_region_y_low (in_region_y_low),
    .in_region_y_high(in_region_y_high),
    .in_region_id    (in_region_id),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_strobe      (out_strobe),
    .out_hit_valid   (out_hit_valid),
    .out_hit_id      (out_hit_id),
    .out_add_dropped (out_add_dropped),
    .mismatches      (mismatches),
    .results_due     (results_due)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // drive one beat at a falling edge and hold it until busy lets it in
  task automatic send_beat(logic op, logic [15:0] rx, logic [15:0] ry, logic [31:0] sec,
                           logic [19:0] usec, region_t reg_in);
    start <= 1'b1;
    in_operation <= op;
    in_raw_x <= rx;
    in_raw_y <= ry;
    in_now_sec <= sec;
    in_now_usec <= usec;
    in_region_x_low <= reg_in.x_low;
    in_region_x_high <= reg_in.x_high;
    in_region_y_low <= reg_in.y_low;
    in_region_y_high <= reg_in.y_high;
    in_region_id <= reg_in.id;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic add_region(logic [15:0] xl, logic [15:0] xh, logic [15:0] yl,
                            logic [15:0] yh, logic [15:0] id);
    send_beat(OP_ADD, 16'($urandom), 16'($urandom), $urandom, 20'($urandom),
              '{id: id, y_high: yh, y_low: yl, x_high: xh, x_low: xl});
    adds_sent++;
  endtask

  task automatic touch(logic [15:0] rx, logic [15:0] ry, logic [31:0] sec, logic [19:0] usec);
    send_beat(OP_TOUCH, rx, ry, sec, usec,
              region_t'({$urandom, $urandom, 16'($urandom)}));
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_hold(logic [HOLD_W-1:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_beat(bit idle_ok);
    logic [15:0] xl;
    logic [15:0] yl;
    int step;
    if (idle_ok && $urandom_range(0, 4) == 0) pause($urandom_range(1, 9));
    if ($urandom_range(0, 99) < ((adds_sent < int'(MAX_REGIONS)) ? 30 : 8)) begin
      if ($urandom_range(0, 7) == 0) begin
        add_region(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom));
      end else begin
        xl = 16'($urandom_range(0, 230));
        yl = 16'($urandom_range(0, 310));
        add_region(xl, xl + 16'($urandom_range(2, 60)), yl, yl + 16'($urandom_range(2, 80)),
                   16'($urandom));
      end
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          step = $urandom_range(0, 300000);
          if (int'(clock_usec) + step > 999999) begin
            clock_sec++;
            clock_usec = 20'(step);
          end else begin
            clock_usec = 20'(int'(clock_usec) + step);
          end
        end
        6, 7: begin
          clock_sec++;
          clock_usec = 20'($urandom_range(0, 999999));
        end
        8: clock_usec = 20'($urandom_range(0, 999999));
        default: begin
          clock_sec = $urandom;
          clock_usec = 20'($urandom_range(0, 999999));
        end
      endcase
      if ($urandom_range(0, 7) == 0) begin
        touch(16'($urandom), 16'($urandom), clock_sec, clock_usec);
      end else begin
        touch(16'($urandom_range(2000, 30000)), 16'($urandom_range(3000, 30000)),
              clock_sec, clock_usec);
      end
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table, then never-hit regions and the screen-edge strip
    touch(16'd16000, 16'd16000, 32'd5, 20'd0);
    add_region(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h1111);
    add_region(16'd100, 16'd100, 16'd50, 16'd50, 16'h2222);
    add_region(16'h0000, 16'hFFFF, 16'd318, 16'hFFFF, 16'hFFFF);
    add_region(16'd100, 16'd140, 16'd100, 16'd200, 16'h0000);
    add_region(16'd10, 16'd60, 16'd10, 16'd80, 16'h5A5A);

    // hold-off at reset in second 0, expiry, negative delta, next second
    touch(16'd15900, 16'd15700, 32'd0, 20'd100);
    touch(16'd15900, 16'd15700, 32'd0, 20'd600000);
    touch(16'd15900, 16'd15700, 32'd0, 20'd700000);
    touch(16'd15900, 16'd15700, 32'd0, 20'd100);
    touch(16'd15900, 16'd15700, 32'd1, 20'd0);

    // clamped corners of the reading range
    touch(16'd0, 16'hFFFF, 32'd2, 20'd0);
    touch(16'hFFFF, 16'd0, 32'd3, 20'd0);
    touch(16'd2000, 16'd3000, 32'd4, 20'd0);
    touch(16'd30000, 16'd30000, 32'd5, 20'd0);
    touch(16'd15900, 16'd15700, 32'd6, 20'hFFFFF);
    touch(16'd26400, 16'd6400, 32'd7, 20'd0);
    touch(16'd18220, 16'd15700, 32'd8, 20'd0);
    touch(16'd26400, 16'd6400, 32'hFFFF_FFFF, 20'd999999);

    // zero hold-off: same instant hits, earlier instant does not
    write_hold('0);
    touch(16'd26400, 16'd6400, 32'hFFFF_FFFF, 20'd999999);
    touch(16'd26400, 16'd6400, 32'hFFFF_FFFF, 20'd999998);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_hold(20'd999999);
        1: write_hold(20'hFFFFF);
        2: write_hold(20'($urandom));
        3: write_hold(HOLD_OFF_RESET);
        4: write_hold(20'($urandom_range(0, 2000)));
        default: write_hold(20'($urandom_range(0, 999999)));
      endcase
      repeat (140) random_beat(phase < 5);
    end

    drain();
    repeat (25) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

/* touch_region_hit_test_top.f */
rtl/trht_pkg.sv
rtl/trht_map.sv
rtl/touch_region_hit_test_top.sv
tb/trht_checker.sv
tb/tb.sv
